FILE: src/rgbfe_pkg.sv
// ----------------------------------------------------------------------------
// rgbfe_pkg
// Shared types and constants for the RGB LED strip frame encoder.
// ----------------------------------------------------------------------------
package rgbfe_pkg;

    // strip type codes
    localparam logic [1:0] STRIP_7BIT = 2'd0;
    localparam logic [1:0] STRIP_8BIT = 2'd1;
    localparam logic [1:0] STRIP_CSUM = 2'd2;

    localparam int          MAX_LEDS_DEFAULT = 256;
    localparam int          LEVEL_W          = 16;
    localparam int          BYTE_W           = 8;
    localparam int          NUM_SLOTS        = 12;
    localparam int          SLOT_W           = 4;
    localparam logic [3:0]  LATCH_CAP        = 4'd9;
    localparam logic [7:0]  FULL_7BIT        = 8'd127;
    localparam logic [7:0]  FULL_8BIT        = 8'd255;
    localparam logic [7:0]  MARK_7BIT        = 8'h80;
    localparam logic [7:0]  FLAG_HEAD        = 8'hC0;

    // per-LED control carried from the input stage to the serializer
    typedef struct packed {
        logic [1:0] mode;
        logic       last;
        logic       prefix;
        logic [3:0] latch;
    } ctl_t;

endpackage

FILE: src/rgbfe_lane.sv
// ----------------------------------------------------------------------------
// rgbfe_lane
// One color channel: scales a Q0.16 level to 7 or 8 bits, round half up,
// clamped to full scale, and registers the result.
// ----------------------------------------------------------------------------
module rgbfe_lane (
    input  logic                         aclk,
    input  logic                         load,
    input  logic                         mode7,
    input  logic [rgbfe_pkg::LEVEL_W-1:0] level,
    output logic [rgbfe_pkg::BYTE_W-1:0]  q
);
    import rgbfe_pkg::*;

    logic [7:0]  full;
    logic [23:0] prod;
    logic [23:0] rounded;
    logic [7:0]  q_raw;
    logic [7:0]  q_reg;
    logic [7:0]  q_next;

    // level * full + one half LSB, keep the integer part
    always_comb begin
        full    = mode7 ? FULL_7BIT : FULL_8BIT;
        prod    = 24'(level) * 24'(full);
        rounded = prod + 24'd32768;
        q_raw   = rounded[23:16];
        q_next  = (q_raw > full) ? full : q_raw;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: src/rgbfe_ser.sv
// ----------------------------------------------------------------------------
// rgbfe_ser
// Merges the three lane results and framing into a byte list of up to
// twelve entries and shifts it out one byte per transaction.
// ----------------------------------------------------------------------------
module rgbfe_ser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rgbfe_pkg::ctl_t             in_ctl,
    input  logic [rgbfe_pkg::BYTE_W-1:0] red,
    input  logic [rgbfe_pkg::BYTE_W-1:0] green,
    input  logic [rgbfe_pkg::BYTE_W-1:0] blue,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // [7:0] wire_byte
    output logic                        m_tlast   // frame_done
);
    import rgbfe_pkg::*;

    logic [7:0]        buf_reg  [NUM_SLOTS];
    logic [7:0]        buf_next [NUM_SLOTS];
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic              last_reg, last_next;
    logic [7:0]        build    [NUM_SLOTS];
    logic [SLOT_W-1:0] build_cnt;
    logic [7:0]        flag;
    logic              at_end;
    logic              done_xfer;
    logic              load;

    // byte list for the incoming LED
    always_comb begin
        flag = FLAG_HEAD | {2'b00, ~blue[7:6], ~green[7:6], ~red[7:6]};
        for (int i = 0; i < NUM_SLOTS; i++) begin
            build[i] = '0;
        end
        build_cnt = SLOT_W'(3);
        case (in_ctl.mode)
            STRIP_7BIT: begin
                build[0]  = red | MARK_7BIT;
                build[1]  = green | MARK_7BIT;
                build[2]  = blue | MARK_7BIT;
                build_cnt = SLOT_W'(3) + (in_ctl.last ? in_ctl.latch : 4'd0);
            end
            STRIP_CSUM: begin
                if (in_ctl.prefix) begin
                    build[4] = flag;
                    build[5] = blue;
                    build[6] = green;
                    build[7] = red;
                    build_cnt = SLOT_W'(8);
                end else begin
                    build[0] = flag;
                    build[1] = blue;
                    build[2] = green;
                    build[3] = red;
                    build_cnt = SLOT_W'(4);
                end
                if (in_ctl.last) begin
                    build_cnt = build_cnt + SLOT_W'(4);
                end
            end
            default: begin
                build[0] = red;
                build[1] = green;
                build[2] = blue;
            end
        endcase
    end

    // handshake
    assign at_end    = (idx_reg == cnt_reg - SLOT_W'(1));
    assign done_xfer = valid_reg && m_tready && at_end;
    assign in_ready  = !valid_reg || done_xfer;
    assign load      = in_valid && in_ready;

    always_comb begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (load) begin
            buf_next   = build;
            cnt_next   = build_cnt;
            idx_next   = '0;
            last_next  = in_ctl.last;
            valid_next = 1'b1;
        end else if (done_xfer) begin
            valid_next = 1'b0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = buf_reg[idx_reg];
    assign m_tlast  = last_reg && at_end;

endmodule

FILE: src/rgb_led_strip_frame_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_encoder
// Converts a stream of RGB LEDs into the SPI byte stream of an LED strip.
// ----------------------------------------------------------------------------
// Each LED is scaled by three channel lanes that register the result as it is taken,
// then handed to a serializer that emits one byte per output transaction.
// An LED yields 3 bytes (plain 8-bit strip), 3 plus 1..9 latch bytes on the
// last LED (7-bit strip), or 4 bytes plus 4 prefix bytes on a frame's first
// LED and 4 suffix bytes on its last (checksum strip). The output serializer
// emits one byte per cycle while m_tready is high and bytes are queued, so
// throughput is set by the byte count of each LED, framing bytes included.
// The next LED is taken while the current one is still being shifted out.
// strip_type may only be written while the encoder is idle.
module rgb_led_strip_frame_encoder #(
    parameter int MAX_LEDS = rgbfe_pkg::MAX_LEDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: strip_type
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // LED input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] red_level, [31:16] green_level,
                                   // [47:32] blue_level
    input  logic        s_tlast,   // last_led
    // SPI byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] wire_byte
    output logic        m_tlast    // frame_done
);
    import rgbfe_pkg::*;

    localparam int LW = $clog2(MAX_LEDS + 1);
    localparam int SW = LW + 4;

    logic [1:0]    strip_reg;
    logic          open_reg, open_next;
    logic [LW-1:0] leds_reg, leds_next;
    logic          s1_valid_reg;
    ctl_t          s1_ctl_reg, ctl_next;
    logic [1:0]    mode;
    logic [SW-1:0] latch_w;
    logic          s_accept;
    logic          ser_ready;
    logic [7:0]    red_q, green_q, blue_q;

    assign cfg_ready = 1'b1;
    assign s_tready  = !s1_valid_reg || ser_ready;
    assign s_accept  = s_tvalid && s_tready;

    // frame bookkeeping at input acceptance
    always_comb begin
        mode      = (strip_reg == STRIP_CSUM || strip_reg == STRIP_7BIT) ? strip_reg
                                                                        : STRIP_8BIT;
        leds_next = (leds_reg < LW'(MAX_LEDS)) ? leds_reg + LW'(1) : leds_reg;
        latch_w   = (SW'(leds_next) + SW'(31)) >> 5;
        ctl_next.mode   = mode;
        ctl_next.last   = s_tlast;
        ctl_next.prefix = (mode == STRIP_CSUM) && !open_reg;
        ctl_next.latch  = (latch_w > SW'(LATCH_CAP)) ? LATCH_CAP : latch_w[3:0];
        open_next = !s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_reg    <= STRIP_8BIT;
            open_reg     <= 1'b0;
            leds_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                strip_reg <= cfg_data;
            end
            if (s_accept) begin
                open_reg <= open_next;
                leds_reg <= s_tlast ? '0 : leds_next;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (ser_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg <= ctl_next;
        end
    end

    // channel lanes
    rgbfe_lane u_lane_r (
        .aclk  (aclk),
        .load  (s_accept),
        .mode7 (mode == STRIP_7BIT),
        .level (s_tdata[15:0]),
        .q     (red_q)
    );

    rgbfe_lane u_lane_g (
        .aclk  (aclk),
        .load  (s_accept),
        .mode7 (mode == STRIP_7BIT),
        .level (s_tdata[31:16]),
        .q     (green_q)
    );

    rgbfe_lane u_lane_b (
        .aclk  (aclk),
        .load  (s_accept),
        .mode7 (mode == STRIP_7BIT),
        .level (s_tdata[47:32]),
        .q     (blue_q)
    );

    // merge and serialize
    rgbfe_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_ready (ser_ready),
        .in_ctl   (s1_ctl_reg),
        .red      (red_q),
        .green    (green_q),
        .blue     (blue_q),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/rgbfe_checker.sv
// ----------------------------------------------------------------------------
// rgbfe_checker
// Port-level checks for the RGB LED strip frame encoder.
// ----------------------------------------------------------------------------
module rgbfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);
    import rgbfe_pkg::*;

    logic [1:0] strip_reg;

    // shadow of the strip type register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_reg <= STRIP_8BIT;
        end else if (cfg_valid && cfg_ready) begin
            strip_reg <= cfg_data;
        end
    end

    // a stalled byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // no output right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // latch and suffix framing ends every 7-bit and checksum frame with zero
    a_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && (strip_reg == STRIP_7BIT || strip_reg == STRIP_CSUM)
        |-> m_tdata == 8'h00)
        else $error("frame did not end with a zero byte");

    // an accepted LED reaches idle output via s1_valid_reg and valid_reg
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output transaction without an accepted LED");

endmodule

bind rgb_led_strip_frame_encoder rgbfe_checker u_rgbfe_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

FILE: bench/tb_rgb_led_strip_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_strip_frame_encoder
// Self-checking bench for the RGB LED strip frame encoder.
// ----------------------------------------------------------------------------
// LEDs are driven into the stream input. An in-bench predictor scales each
// channel and builds the expected SPI bytes for the active strip type. Each
// output transaction is checked against the oldest expected byte. Strip type
// changes happen only once the encoder has drained. Coverage includes
// rounding and clamp edges, frames that change type while open, latch byte
// counts, a saturating frame, a long output hold-off and random frames.
// Both sides idle at random, except during one stretch.
// ----------------------------------------------------------------------------
module tb_rgb_led_strip_frame_encoder;
    import rgbfe_pkg::*;

    localparam int          LED_CAP      = MAX_LEDS_DEFAULT;
    localparam logic [1:0]  STRIP_SPARE  = 2'd3;   // unused code, acts as 8-bit
    localparam int unsigned ROUND_HALF   = 32'd32768;
    localparam int          IDLE_PCT     = 17;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          RANDOM_LEDS  = 24;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_done;
    } spi_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // [15:0] red_level, [31:16] green_level,
                             // [47:32] blue_level
    logic        s_tlast;    // last_led
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] wire_byte
    logic        m_tlast;    // frame_done

    // predictor state
    logic [1:0]  strip_sel;
    logic        frame_active;
    int          led_count;
    spi_byte_t   spi_bytes_due[$];

    // bench bookkeeping
    int          errors;
    int          cycles;
    int          leds_sent;
    int          frames_sent;
    int          bytes_checked;
    logic        steady;          // 1 disables random idling on both sides
    logic        hold_pending;    // asks the receiver for a long hold-off
    int          hold_left;

    rgb_led_strip_frame_encoder #(
        .MAX_LEDS(LED_CAP)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still expected", $time,
                     spi_bytes_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Q0.16 level to chip scale, round half up, clamp
    function automatic logic [7:0] scale_channel(logic [15:0] level, logic [7:0] full);
        int unsigned q;
        q = (32'(level) * 32'(full) + ROUND_HALF) >> 16;
        return (q > 32'(full)) ? full : q[7:0];
    endfunction

    // expected SPI bytes for one LED, in wire order
    function automatic void encode_led(logic [15:0] r_lvl, logic [15:0] g_lvl,
                                       logic [15:0] b_lvl, logic last);
        logic [1:0] mode;
        logic [7:0] full;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] flag;
        int         n_latch;
        logic [7:0] wire_seq[$];
        spi_byte_t  item;

        mode = (strip_sel == STRIP_SPARE) ? STRIP_8BIT : strip_sel;
        full = (mode == STRIP_7BIT) ? FULL_7BIT : FULL_8BIT;
        r = scale_channel(r_lvl, full);
        g = scale_channel(g_lvl, full);
        b = scale_channel(b_lvl, full);
        if (led_count < LED_CAP)
            led_count++;

        case (mode)
            STRIP_7BIT: begin
                wire_seq.push_back(r | MARK_7BIT);
                wire_seq.push_back(g | MARK_7BIT);
                wire_seq.push_back(b | MARK_7BIT);
                if (last) begin
                    n_latch = (led_count + 31) / 32;
                    if (n_latch > int'(LATCH_CAP))
                        n_latch = int'(LATCH_CAP);
                    repeat (n_latch) wire_seq.push_back(8'h00);
                end
            end
            STRIP_8BIT: begin
                wire_seq.push_back(r);
                wire_seq.push_back(g);
                wire_seq.push_back(b);
            end
            default: begin
                flag = FLAG_HEAD | {2'b00, ~b[7:6], ~g[7:6], ~r[7:6]};
                if (!frame_active)
                    repeat (4) wire_seq.push_back(8'h00);
                wire_seq.push_back(flag);
                wire_seq.push_back(b);
                wire_seq.push_back(g);
                wire_seq.push_back(r);
                if (last)
                    repeat (4) wire_seq.push_back(8'h00);
            end
        endcase

        foreach (wire_seq[i]) begin
            item.wire_byte  = wire_seq[i];
            item.frame_done = last && (i == wire_seq.size() - 1);
            spi_bytes_due.push_back(item);
        end

        if (last) begin
            frame_active = 1'b0;
            led_count    = 0;
            frames_sent++;
        end else begin
            frame_active = 1'b1;
        end
        leds_sent++;
    endfunction

    // output check: every accepted byte against the oldest expectation
    always @(posedge aclk) begin
        spi_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (spi_bytes_due.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h done %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = spi_bytes_due.pop_front();
                if (m_tdata !== want.wire_byte) begin
                    $display("%0t: wire_byte mismatch, expected %02h, actual %02h",
                             $time, want.wire_byte, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.frame_done) begin
                    $display("%0t: frame_done mismatch, expected %0b, actual %0b",
                             $time, want.frame_done, m_tlast);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one LED transaction; returns just after the accepting edge
    task automatic send_led(logic [15:0] r_lvl, logic [15:0] g_lvl,
                            logic [15:0] b_lvl, logic last);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b_lvl, g_lvl, r_lvl};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        encode_led(r_lvl, g_lvl, b_lvl, last);
    endtask

    // stop sending and wait for every expected byte, then let the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (spi_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // strip_type write, only once the encoder has drained
    task automatic set_strip(logic [1:0] kind);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= kind;
        do @(posedge aclk); while (!cfg_ready);
        strip_sel = kind;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly uniform, with extremes and the half-scale rounding point
    function automatic logic [15:0] rand_level();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000 - 16'(2) + 16'($urandom_range(4));
            3:       return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    // default strip type right after reset, no register write
    task automatic test_reset_default();
        send_led(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_led(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_led(16'h0080, 16'h0081, 16'h7FFF, 1'b1);
    endtask

    // rounding, clamping and flag bits in every strip type
    task automatic test_scaling_edges();
        logic [1:0] kinds[3];
        kinds = '{STRIP_7BIT, STRIP_CSUM, STRIP_SPARE};
        foreach (kinds[i]) begin
            set_strip(kinds[i]);
            send_led(16'hFFFF, 16'h0000, 16'h8000, 1'b0);
            send_led(16'h7FFF, 16'h4000, 16'hC000, 1'b0);
            send_led(16'h0080, 16'h0081, 16'h5555, 1'b1);
        end
        // single-LED checksum frame: prefix and suffix around one LED
        set_strip(STRIP_CSUM);
        send_led(16'hAAAA, 16'h3FFF, 16'hBFFF, 1'b1);
    endtask

    // strip type changed while a frame is open
    task automatic test_mid_frame_switch();
        set_strip(STRIP_8BIT);
        send_led(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
        set_strip(STRIP_CSUM);
        send_led(16'hFEDC, 16'hBA98, 16'h7654, 1'b0);
        set_strip(STRIP_7BIT);
        send_led(16'h0F0F, 16'hF0F0, 16'h00FF, 1'b1);
        set_strip(STRIP_CSUM);
        send_led(16'hFFFF, 16'h0000, 16'h8000, 1'b0);
        set_strip(STRIP_8BIT);
        send_led(16'h4000, 16'h8000, 16'hC000, 1'b0);
        set_strip(STRIP_CSUM);
        send_led(16'h0001, 16'hFFFE, 16'h7F80, 1'b1);
    endtask

    // latch byte count steps from one to two at 33 LEDs; no idling here
    task automatic test_latch_count();
        set_strip(STRIP_7BIT);
        steady = 1'b1;
        for (int k = 0; k < 32; k++)
            send_led(rand_level(), rand_level(), rand_level(), k == 31);
        for (int k = 0; k < 33; k++)
            send_led(rand_level(), rand_level(), rand_level(), k == 32);
        wait_idle();
        steady = 1'b0;
    endtask

    // frame longer than the MAX_LEDS limit, so the LED counter saturates
    task automatic test_counter_saturation();
        set_strip(STRIP_7BIT);
        for (int k = 0; k < 258; k++)
            send_led(rand_level(), rand_level(), rand_level(), k == 257);
    endtask

    // receiver holds off while LEDs keep coming, then the output drains
    task automatic test_output_holdoff();
        logic [1:0] kinds[2];
        kinds = '{STRIP_CSUM, STRIP_7BIT};
        foreach (kinds[i]) begin
            set_strip(kinds[i]);
            hold_pending = 1'b1;
            for (int k = 0; k < 8; k++)
                send_led(rand_level(), rand_level(), rand_level(), k == 7);
            wait_idle();
        end
    endtask

    // random frames and strip types, with occasional mid-frame switches
    task automatic test_random_frames();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_LEDS) begin
            if ($urandom_range(2) == 0)
                set_strip(2'($urandom_range(3)));
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(19) == 0)
                    set_strip(2'($urandom_range(3)));
                send_led(rand_level(), rand_level(), rand_level(), k == len - 1);
                sent++;
            end
        end
    endtask

    // sequence of tests
    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = STRIP_8BIT;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        strip_sel    = STRIP_8BIT;
        frame_active = 1'b0;
        led_count    = 0;
        errors       = 0;
        cycles       = 0;
        leds_sent    = 0;
        frames_sent  = 0;
        bytes_checked = 0;
        steady       = 1'b0;
        hold_pending = 1'b0;
        hold_left    = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_default();
        test_scaling_edges();
        test_mid_frame_switch();
        test_latch_count();
        test_counter_saturation();
        test_output_holdoff();
        test_random_frames();

        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        if (spi_bytes_due.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time,
                     spi_bytes_due.size());
            errors++;
        end

        $display("Run covered %0d LEDs in %0d frames over strip types 0 to 3,",
                 leds_sent, frames_sent);
        $display("checking %0d SPI bytes with %0d errors.", bytes_checked, errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
